FILE: rtl/core/tsvf_pkg.sv
package tsvf_pkg;

  // Shared multiplier operand width
  localparam int unsigned MUL_W = 32;

  // Wide intermediate values saturate at +-2^61 state LSBs
  localparam int unsigned WIDE_W = 63;
  localparam int unsigned MAG_W  = 62;
  localparam logic signed [63:0] WIDE_LIM = 64'sd1 <<< 61;

  // Damping k carries 28 fraction bits
  localparam int unsigned DAMP_FRAC_BITS = 28;

  // Response codes carried on the input tuser
  localparam logic [1:0] MODE_LP = 2'd0;
  localparam logic [1:0] MODE_BP = 2'd1;

  // Register indexes of the configuration port
  typedef enum logic [1:0] {
    CFG_A1      = 2'd0,
    CFG_A2      = 2'd1,
    CFG_A3      = 2'd2,
    CFG_DAMPING = 2'd3
  } cfg_idx_e;

  // Sequencer steps
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_LO,
    ST_HI,
    ST_FIN,
    ST_ACC,
    ST_HP,
    ST_DONE
  } state_e;

  // Coefficient products in issue order
  typedef enum logic [2:0] {
    PR_A1_I1,
    PR_A2_V3,
    PR_A2_I1,
    PR_A3_V3,
    PR_K_V1
  } prod_e;

  // Clamp a wide sum to +-2^61
  function automatic logic signed [WIDE_W-1:0] sat_wide(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = v;
    if (v > WIDE_LIM) begin
      r = WIDE_LIM;
    end else if (v < -WIDE_LIM) begin
      r = -WIDE_LIM;
    end
    return WIDE_W'(r);
  endfunction

endpackage

FILE: rtl/core/trapezoidal_state_variable_filter.sv
// Channel    Dir  Payload                                   Handshake
// s_axis     in   tdata: sample_in; tuser: mode             s_axis_tvalid / s_axis_tready
// m_axis     out  tdata: sample_out; tuser: clipped         m_axis_tvalid / m_axis_tready
// cfg        in   cfg_index_i, cfg_data_i                   cfg_valid_i / cfg_ready_o
//
// Each request runs five coefficient products through one shared 32x32 multiplier,
// each product going through operand prep, low half, high half and rounding, merge and
// cap, and accumulate, then one high-pass combine and one output/state update step.
// Reset clears the integrators, the coefficients and all handshake state.
// The result waits in an output register; a stalled result holds the last step
// until m_axis_tready frees the register. Configuration writes are always taken.
module trapezoidal_state_variable_filter #(
  parameter int unsigned SAMPLE_WIDTH   = 24,
  parameter int unsigned COEF_FRAC_BITS = 30,
  parameter int unsigned GUARD_BITS     = 8
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  tsvf_pkg::cfg_idx_e                      cfg_index_i,
  input  logic [31:0]                             cfg_data_i,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       s_axis_tdata,   // sample_in
  input  logic [1:0]                              s_axis_tuser,   // mode
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       m_axis_tdata,   // sample_out
  output logic [0:0]                              m_axis_tuser    // clipped
);
  import tsvf_pkg::*;

  localparam int unsigned DW  = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int unsigned STW = SAMPLE_WIDTH + GUARD_BITS;
  localparam int unsigned V3W = STW + 1;
  localparam int unsigned SH_COEF = MUL_W - COEF_FRAC_BITS;
  localparam int unsigned SH_DAMP = MUL_W - DAMP_FRAC_BITS;
  localparam logic signed [63:0] S_MAX = (64'sd1 <<< (STW - 1)) - 64'sd1;
  localparam logic signed [63:0] S_MIN = -S_MAX - 64'sd1;
  localparam logic signed [63:0] O_MAX = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] O_MIN = -O_MAX - 64'sd1;
  localparam logic signed [63:0] HALF  = 64'sd1 <<< (GUARD_BITS - 1);
  localparam logic [63:0] LIM_U  = 64'(WIDE_LIM);
  localparam logic [63:0] CAP_CO = LIM_U >> SH_COEF;
  localparam logic [63:0] CAP_DA = LIM_U >> SH_DAMP;

  // Configuration registers
  logic [30:0] a1_q, a2_q, a3_q;
  logic [31:0] k_q;

  // Control
  state_e state_q, state_d;
  prod_e  prod_q, prod_d;
  logic   out_valid_q, out_valid_d;

  // Filter state
  logic signed [STW-1:0] integ1_q, integ1_d, integ2_q, integ2_d;

  // Per-request datapath
  logic [1:0]               mode_q, mode_d;
  logic signed [STW-1:0]    xs_q, xs_d;
  logic signed [V3W-1:0]    v3_q, v3_d;
  logic signed [WIDE_W-1:0] v1_q, v1_d, v2_q, v2_d, h_q, h_d;
  logic [MAG_W-1:0]         mag_q, mag_d, r_q, r_d;
  logic                     neg_q, neg_d;
  logic [63:0]              plo_q, plo_d, phi_q, phi_d, rlo_q, rlo_d;
  logic [SAMPLE_WIDTH-1:0]  out_data_q, out_data_d;
  logic                     clip_q, clip_d;

  // Shared units
  logic [MUL_W-1:0]         mul_a, coef_sel;
  logic [63:0]              mul_p;
  logic signed [WIDE_W-1:0] op_sel, sa, sb, sat_res, pr;
  logic                     accept;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = DW'(out_data_q);
  assign m_axis_tuser  = clip_q;

  // Shared multiplier and saturating adder
  assign mul_p   = 64'(mul_a) * 64'(coef_sel);
  assign sat_res = sat_wide(64'(sa) + 64'(sb));
  assign pr      = $signed({1'b0, r_q});

  // Feed the low or the high half of the magnitude to the multiplier
  always_comb begin
    mul_a = mag_q[MUL_W-1:0];
    if (state_q == ST_HI) begin
      mul_a = MUL_W'(mag_q[MAG_W-1:MUL_W]);
    end
  end

  // Pick the operands of the shared adder
  always_comb begin
    sa = '0;
    sb = pr;
    unique case (state_q)
      ST_ACC: begin
        sb = neg_q ? -pr : pr;
        unique case (prod_q)
          PR_A1_I1: sa = '0;
          PR_A2_V3: sa = v1_q;
          PR_A2_I1: sa = WIDE_W'(integ2_q);
          PR_A3_V3: sa = v2_q;
          PR_K_V1: begin
            sa = WIDE_W'(xs_q);
            sb = neg_q ? pr : -pr;
          end
          default: sa = '0;
        endcase
      end
      ST_HP: begin
        sa = h_q;
        sb = -v2_q;
      end
      default: begin
        sa = '0;
        sb = pr;
      end
    endcase
  end

  // Pick operand and coefficient of the current product
  always_comb begin
    op_sel   = WIDE_W'(integ1_q);
    coef_sel = {1'b0, a1_q};
    unique case (prod_q)
      PR_A1_I1: begin
        op_sel   = WIDE_W'(integ1_q);
        coef_sel = {1'b0, a1_q};
      end
      PR_A2_V3: begin
        op_sel   = WIDE_W'(v3_q);
        coef_sel = {1'b0, a2_q};
      end
      PR_A2_I1: begin
        op_sel   = WIDE_W'(integ1_q);
        coef_sel = {1'b0, a2_q};
      end
      PR_A3_V3: begin
        op_sel   = WIDE_W'(v3_q);
        coef_sel = {1'b0, a3_q};
      end
      PR_K_V1: begin
        op_sel   = v1_q;
        coef_sel = k_q;
      end
      default: begin
        op_sel   = WIDE_W'(integ1_q);
        coef_sel = {1'b0, a1_q};
      end
    endcase
  end

  // Sequencer: next state and datapath updates
  always_comb begin
    logic [63:0]        sum_co, sum_da, r_full;
    logic signed [WIDE_W-1:0] y;
    logic signed [63:0] yr, q, t1, t2;

    state_d     = state_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q;
    integ1_d    = integ1_q;
    integ2_d    = integ2_q;
    mode_d      = mode_q;
    xs_d        = xs_q;
    v3_d        = v3_q;
    v1_d        = v1_q;
    v2_d        = v2_q;
    h_d         = h_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    plo_d       = plo_q;
    phi_d       = phi_q;
    rlo_d       = rlo_q;
    r_d         = r_q;
    out_data_d  = out_data_q;
    clip_d      = clip_q;
    sum_co      = (phi_q << SH_COEF) + rlo_q;
    sum_da      = (phi_q << SH_DAMP) + rlo_q;
    r_full      = '0;
    y           = h_q;
    yr          = '0;
    q           = '0;
    t1          = '0;
    t2          = '0;

    // Drop the result once taken
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          xs_d    = $signed({s_axis_tdata[SAMPLE_WIDTH-1:0], {GUARD_BITS{1'b0}}});
          v3_d    = V3W'(xs_d) - V3W'(integ2_q);
          mode_d  = s_axis_tuser;
          prod_d  = PR_A1_I1;
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        // Split the operand into sign and magnitude
        neg_d   = op_sel[WIDE_W-1];
        mag_d   = neg_d ? MAG_W'(-op_sel) : MAG_W'(op_sel);
        state_d = ST_LO;
      end
      ST_LO: begin
        plo_d   = mul_p;
        state_d = ST_HI;
      end
      ST_HI: begin
        phi_d = mul_p;
        // Round the low partial product, halves up on the magnitude
        if (prod_q == PR_K_V1) begin
          rlo_d = (plo_q >> DAMP_FRAC_BITS) + 64'(plo_q[DAMP_FRAC_BITS-1]);
        end else begin
          rlo_d = (plo_q >> COEF_FRAC_BITS) + 64'(plo_q[COEF_FRAC_BITS-1]);
        end
        state_d = ST_FIN;
      end
      ST_FIN: begin
        // Merge partial products and cap the magnitude
        if (prod_q == PR_K_V1) begin
          r_full = (phi_q > CAP_DA || sum_da > LIM_U) ? LIM_U : sum_da;
        end else begin
          r_full = (phi_q > CAP_CO || sum_co > LIM_U) ? LIM_U : sum_co;
        end
        r_d     = MAG_W'(r_full);
        state_d = ST_ACC;
      end
      ST_ACC: begin
        unique case (prod_q)
          PR_A1_I1: begin
            v1_d   = sat_res;
            prod_d = PR_A2_V3;
          end
          PR_A2_V3: begin
            v1_d   = sat_res;
            prod_d = PR_A2_I1;
          end
          PR_A2_I1: begin
            v2_d   = sat_res;
            prod_d = PR_A3_V3;
          end
          PR_A3_V3: begin
            v2_d   = sat_res;
            prod_d = PR_K_V1;
          end
          PR_K_V1: begin
            h_d  = sat_res;
          end
          default: begin
            prod_d = prod_q;
          end
        endcase
        state_d = (prod_q == PR_K_V1) ? ST_HP : ST_PREP;
      end
      ST_HP: begin
        h_d     = sat_res;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // Hold until the output register is free
        if (!out_valid_q || m_axis_tready) begin
          case (mode_q)
            MODE_LP: y = v2_q;
            MODE_BP: y = v1_q;
            default: y = h_q;
          endcase
          yr = 64'(y) + HALF;
          q  = yr >>> GUARD_BITS;
          if (q > O_MAX) begin
            out_data_d = SAMPLE_WIDTH'(O_MAX);
            clip_d     = 1'b1;
          end else if (q < O_MIN) begin
            out_data_d = SAMPLE_WIDTH'(O_MIN);
            clip_d     = 1'b1;
          end else begin
            out_data_d = SAMPLE_WIDTH'(q);
            clip_d     = 1'b0;
          end
          // Advance the integrators
          t1 = (64'(v1_q) <<< 1) - 64'(integ1_q);
          t2 = (64'(v2_q) <<< 1) - 64'(integ2_q);
          if (t1 > S_MAX) begin
            integ1_d = STW'(S_MAX);
          end else if (t1 < S_MIN) begin
            integ1_d = STW'(S_MIN);
          end else begin
            integ1_d = STW'(t1);
          end
          if (t2 > S_MAX) begin
            integ2_d = STW'(S_MAX);
          end else if (t2 < S_MIN) begin
            integ2_d = STW'(S_MIN);
          end else begin
            integ2_d = STW'(t2);
          end
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control, filter state and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prod_q      <= PR_A1_I1;
      out_valid_q <= 1'b0;
      integ1_q    <= '0;
      integ2_q    <= '0;
      a1_q        <= '0;
      a2_q        <= '0;
      a3_q        <= '0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      prod_q      <= prod_d;
      out_valid_q <= out_valid_d;
      integ1_q    <= integ1_d;
      integ2_q    <= integ2_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_A1:      a1_q <= cfg_data_i[30:0];
          CFG_A2:      a2_q <= cfg_data_i[30:0];
          CFG_A3:      a3_q <= cfg_data_i[30:0];
          CFG_DAMPING: k_q  <= cfg_data_i;
          default:     k_q  <= k_q;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    xs_q       <= xs_d;
    v3_q       <= v3_d;
    v1_q       <= v1_d;
    v2_q       <= v2_d;
    h_q        <= h_d;
    mag_q      <= mag_d;
    neg_q      <= neg_d;
    plo_q      <= plo_d;
    phi_q      <= phi_d;
    rlo_q      <= rlo_d;
    r_q        <= r_d;
    out_data_q <= out_data_d;
    clip_q     <= clip_d;
  end

endmodule
